/* rtl/skgr_pkg.sv */
// shared constants and types for the stream group reverser
`timescale 1ns / 1ps
`default_nettype none

package skgr_pkg;

  // default sizing of the group buffer
  localparam int DEF_MAX_GROUP  = 16;
  localparam int DEF_VALUE_BITS = 32;

  // fixed widths of the stream fields and the group size register
  localparam int ITEM_BITS = 32;
  localparam int CFG_BITS  = 5;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SEND
  } skgr_state_t;

endpackage

`default_nettype wire

/* rtl/skgr_buffer.sv */
// group buffer memory, one write and one registered read port
`timescale 1ns / 1ps
`default_nettype none

module skgr_buffer #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/stream_k_group_reverser.sv */
// top level: stream group reverser with buffer control
`timescale 1ns / 1ps
`default_nettype none

// Reorders a stream of values in groups of group_size items.
// Input requests arrive on s_axis (tdata = value, tlast = end of sequence).
// Each request is written into the group buffer at the current fill count.
// When the buffer holds group_size items the group is sent on m_axis in
// reverse order; when tlast arrives first, the partial group is sent in
// arrival order. m_axis_tlast marks the final result of a tlast request.
// group_size is written through cfg_we / cfg_wdata; the user must write it
// only while idle, as the block itself does not enforce this. Zero acts as one
// and values above MAX_GROUP act as MAX_GROUP. A request that does not close
// a group is stored and s_axis_tready stays high. A closing request leads to
// ST_LOAD, which starts the registered buffer read of the first result, then
// to ST_SEND, where results go out one per cycle while the receiver is ready,
// n results for a group of n. s_axis_tready is low in ST_LOAD and while a
// group is sent. When the receiver stalls, the result and the buffer read
// address hold. Reset empties the buffer count and sets group_size to 1.
module stream_k_group_reverser #(
  parameter int MAX_GROUP  = skgr_pkg::DEF_MAX_GROUP,
  parameter int VALUE_BITS = skgr_pkg::DEF_VALUE_BITS
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // configuration
  input  wire logic                           cfg_we,
  input  wire logic [skgr_pkg::CFG_BITS-1:0]  cfg_wdata,
  // input stream
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [skgr_pkg::ITEM_BITS-1:0] s_axis_tdata,  // [31:0] item_value
  input  wire logic                           s_axis_tlast,  // item_last
  // output stream
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output logic      [skgr_pkg::ITEM_BITS-1:0] m_axis_tdata,  // [31:0] out_value
  output logic                                m_axis_tlast   // out_last
);

  import skgr_pkg::*;

  localparam int CW = $clog2(MAX_GROUP + 1);
  localparam int AW = $clog2(MAX_GROUP);
  localparam int KW = (CW > CFG_BITS) ? CW : CFG_BITS;

  skgr_state_t   state, state_next;
  logic [CFG_BITS-1:0] group_size;
  logic [CW-1:0] fill, fill_next;
  logic [CW-1:0] emit_n, emit_n_next;
  logic [CW-1:0] emit_idx, emit_idx_next;
  logic          rev, rev_next;
  logic          last_flag, last_flag_next;

  logic [KW-1:0] k_eff;
  logic [CW-1:0] n_cnt;
  logic          in_req;
  logic          out_req;
  logic          emit_end;
  logic          rd_en;
  logic [CW-1:0] rd_j;
  logic [CW-1:0] rd_pos;
  logic [VALUE_BITS-1:0] wr_data;
  logic [VALUE_BITS-1:0] rd_data;
  logic [63:0]   in_wide;
  logic [63:0]   rd_wide;

  // group size register
  always_ff @(posedge clk) begin
    if (rst) begin
      group_size <= CFG_BITS'(1);
    end else if (cfg_we) begin
      group_size <= cfg_wdata;
    end
  end

  // effective group size, clamped to 1..MAX_GROUP
  always_comb begin
    if (group_size == '0) begin
      k_eff = KW'(1);
    end else if (KW'(group_size) > KW'(MAX_GROUP)) begin
      k_eff = KW'(MAX_GROUP);
    end else begin
      k_eff = KW'(group_size);
    end
  end

  assign in_req   = s_axis_tvalid && s_axis_tready;
  assign out_req  = m_axis_tvalid && m_axis_tready;
  assign n_cnt    = fill + CW'(1);
  assign emit_end = (emit_idx == emit_n - CW'(1));

  // value width adaption into and out of the buffer
  assign in_wide = {32'b0, s_axis_tdata};
  assign wr_data = in_wide[VALUE_BITS-1:0];
  assign rd_wide = 64'(rd_data);

  // read address: position of the next result in buffer order
  assign rd_j   = (state == ST_SEND) ? emit_idx + CW'(1) : emit_idx;
  assign rd_pos = rev ? emit_n - CW'(1) - rd_j : rd_j;

  // controller state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      fill      <= '0;
      emit_n    <= '0;
      emit_idx  <= '0;
      rev       <= 1'b0;
      last_flag <= 1'b0;
    end else begin
      state     <= state_next;
      fill      <= fill_next;
      emit_n    <= emit_n_next;
      emit_idx  <= emit_idx_next;
      rev       <= rev_next;
      last_flag <= last_flag_next;
    end
  end

  // next state and handshake outputs
  always_comb begin
    state_next     = state;
    fill_next      = fill;
    emit_n_next    = emit_n;
    emit_idx_next  = emit_idx;
    rev_next       = rev;
    last_flag_next = last_flag;
    s_axis_tready  = 1'b0;
    m_axis_tvalid  = 1'b0;
    rd_en          = 1'b0;
    case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (in_req) begin
          if ((KW'(n_cnt) >= k_eff) || s_axis_tlast) begin
            emit_n_next    = n_cnt;
            emit_idx_next  = '0;
            rev_next       = (KW'(n_cnt) >= k_eff);
            last_flag_next = s_axis_tlast;
            fill_next      = '0;
            state_next     = ST_LOAD;
          end else begin
            fill_next = n_cnt;
          end
        end
      end
      ST_LOAD: begin
        rd_en      = 1'b1;
        state_next = ST_SEND;
      end
      ST_SEND: begin
        m_axis_tvalid = 1'b1;
        if (out_req) begin
          if (emit_end) begin
            state_next = ST_IDLE;
          end else begin
            rd_en         = 1'b1;
            emit_idx_next = emit_idx + CW'(1);
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // output payload straight from the registered buffer read
  assign m_axis_tdata = rd_wide[ITEM_BITS-1:0];
  assign m_axis_tlast = last_flag && emit_end;

  // group buffer
  skgr_buffer #(
    .DEPTH (MAX_GROUP),
    .WIDTH (VALUE_BITS)
  ) u_buffer (
    .clk   (clk),
    .we    (in_req),
    .waddr (fill[AW-1:0]),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_pos[AW-1:0]),
    .rdata (rd_data)
  );

endmodule

`default_nettype wire
